[design/lbr_pkg.sv]
// ----------------------------------------------------------------------------
// LSB-first bit reader package
// Shared widths, op codes and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbr_pkg;

  localparam int ADDR_W    = 12;               // byte address into the buffer
  localparam int BUF_BYTES = 1 << ADDR_W;
  localparam int DATA_W    = 8;
  localparam int NUM_W     = 6;
  localparam int MAX_BITS  = 32;
  localparam int LOC_W     = ADDR_W + 3;       // byte address plus bit offset
  localparam int VAL_W     = 32;
  localparam int WIN_BYTES = (MAX_BITS + 7 + 7) / 8;
  localparam int WIN_W     = WIN_BYTES * DATA_W;
  localparam int CNT_W     = 3;                // counts 0..WIN_BYTES

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;
  localparam logic [1:0] OP_SEEK = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic latch;    // capture the input word
    logic exec;     // perform load/seek, set up a fetch
    logic fetch;    // stream buffer bytes into the window
    logic finish;   // form the result, advance position on read
  } lbr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic extract;     // latched op needs buffer bytes
    logic fetch_done;  // all bytes are in the window
  } lbr_status_t;

endpackage

`default_nettype wire

[design/lbr_datapath.sv]
// ----------------------------------------------------------------------------
// LSB-first bit reader datapath
// Byte buffer, bit position, byte fetch window and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbr_datapath (
  input  wire                            clk,
  input  wire                            rst,
  input  lbr_pkg::lbr_cmd_t              cmd,
  output lbr_pkg::lbr_status_t           status,
  input  wire  [1:0]                     op,
  input  wire  [lbr_pkg::ADDR_W-1:0]     byte_addr,
  input  wire  [lbr_pkg::DATA_W-1:0]     byte_data,
  input  wire  [lbr_pkg::NUM_W-1:0]      num_bits,
  input  wire  [lbr_pkg::LOC_W-1:0]      bit_loc,
  output logic [lbr_pkg::VAL_W-1:0]      value,
  output logic [lbr_pkg::LOC_W-1:0]      position
);
  import lbr_pkg::*;

  logic [DATA_W-1:0] mem [BUF_BYTES];

  logic [1:0]        op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] data_q;
  logic [NUM_W-1:0]  n_q;
  logic [LOC_W-1:0]  loc_q;

  logic [LOC_W-1:0]  pos;
  logic [LOC_W-1:0]  start_loc;
  logic [NUM_W-1:0]  need_sum;
  logic [ADDR_W-1:0] rd_addr;
  logic [2:0]        off;
  logic [CNT_W-1:0]  nb;
  logic [CNT_W-1:0]  issued;
  logic [CNT_W-1:0]  recv;
  logic              rd_vld;
  logic              issue;
  logic [DATA_W-1:0] rdata;
  logic [WIN_W-1:0]  window;
  logic [WIN_W-1:0]  win_shift;
  logic [VAL_W:0]    mask_wide;
  logic              is_extract;

  // Capture the input word, saturate the bit count
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= op;
      addr_q <= byte_addr;
      data_q <= byte_data;
      loc_q  <= bit_loc;
      if (num_bits > NUM_W'(MAX_BITS)) begin
        n_q <= NUM_W'(MAX_BITS);
      end else begin
        n_q <= num_bits;
      end
    end
  end

  assign is_extract = ((op_q == OP_READ) || (op_q == OP_PEEK)) && (n_q != '0);
  assign start_loc  = (op_q == OP_READ) ? pos : loc_q;
  assign need_sum   = NUM_W'(start_loc[2:0]) + n_q + NUM_W'(7);

  // Byte buffer: write on load, registered read while fetching
  assign issue = cmd.fetch && (issued != nb);

  always_ff @(posedge clk) begin
    if (cmd.exec && (op_q == OP_LOAD)) begin
      mem[addr_q] <= data_q;
    end
    if (issue) begin
      rdata <= mem[rd_addr];
    end
  end

  // Bit position: seek sets it, read advances it with wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.exec && (op_q == OP_SEEK)) begin
      pos <= loc_q;
    end else if (cmd.finish && (op_q == OP_READ)) begin
      pos <= pos + LOC_W'(n_q);
    end
  end

  // Fetch sequencing: issue addresses, collect bytes into the window
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      issued <= '0;
      recv   <= '0;
    end else if (cmd.exec) begin
      rd_vld <= 1'b0;
      issued <= '0;
      recv   <= '0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        issued <= issued + CNT_W'(1);
      end
      if (rd_vld) begin
        recv <= recv + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_addr <= start_loc[LOC_W-1:3];
      off     <= start_loc[2:0];
      nb      <= is_extract ? need_sum[NUM_W-1:3] : '0;
      window  <= '0;
    end else begin
      if (issue) begin
        rd_addr <= rd_addr + ADDR_W'(1);
      end
      if (rd_vld) begin
        for (int k = 0; k < WIN_BYTES; k++) begin
          if (recv == CNT_W'(k)) begin
            window[k*DATA_W +: DATA_W] <= rdata;
          end
        end
      end
    end
  end

  assign status.extract    = is_extract;
  assign status.fetch_done = (recv == nb) && !rd_vld;

  // Align and mask the result
  assign win_shift = window >> off;
  assign mask_wide = ~({(VAL_W+1){1'b1}} << n_q);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (is_extract) begin
        value <= win_shift[VAL_W-1:0] & mask_wide[VAL_W-1:0];
      end else begin
        value <= '0;
      end
    end
  end

  assign position = pos;

endmodule

`default_nettype wire

[design/lbr_ctrl.sv]
// ----------------------------------------------------------------------------
// LSB-first bit reader controller
// Sequences accept, execute, byte fetch and finish; drives busy and done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbr_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  output logic                  done,
  output lbr_pkg::lbr_cmd_t     cmd,
  input  lbr_pkg::lbr_status_t  status
);
  import lbr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_FETCH  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = status.extract ? S_FETCH : S_FINISH;
      end
      S_FETCH: begin
        if (status.fetch_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
    end
  end

  // Commands
  assign busy       = (state != S_IDLE);
  assign cmd.latch  = (state == S_IDLE) && start;
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.fetch  = (state == S_FETCH);
  assign cmd.finish = (state == S_FINISH);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_busy_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  a_fetch_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH && !status.fetch_done) |=> state == S_FETCH)
    else $error("fetch left before all bytes arrived");

endmodule

`default_nettype wire

[design/lsb_first_bit_reader.sv]
// ----------------------------------------------------------------------------
// LSB-first bit reader
// Byte buffer with a bit position; load, read, peek and seek commands.
// ----------------------------------------------------------------------------
// Sequence: accept, execute and finish for load, seek and zero-length reads,
//   plus a byte fetch for a read/peek that spans B buffer bytes (B <= 5).
// A new word is accepted only when idle; the single buffer read port
//   fetches one byte per cycle. start is taken again in the done cycle.
// Reset clears the bit position to zero; buffer contents are undefined
//   until loaded. The receiver cannot stall: each result is shown once.
`timescale 1ns / 1ps
`default_nettype none

module lsb_first_bit_reader (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire  [1:0]                  op,
  input  wire  [lbr_pkg::ADDR_W-1:0]  byte_addr,
  input  wire  [lbr_pkg::DATA_W-1:0]  byte_data,
  input  wire  [lbr_pkg::NUM_W-1:0]   num_bits,
  input  wire  [lbr_pkg::LOC_W-1:0]   bit_loc,
  output logic                        done,
  output logic [lbr_pkg::VAL_W-1:0]   value,
  output logic [lbr_pkg::LOC_W-1:0]   position
);
  import lbr_pkg::*;

  lbr_cmd_t    cmd;
  lbr_status_t status;

  lbr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  lbr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .op        (op),
    .byte_addr (byte_addr),
    .byte_data (byte_data),
    .num_bits  (num_bits),
    .bit_loc   (bit_loc),
    .value     (value),
    .position  (position)
  );

endmodule

`default_nettype wire
